[hw/rtl/amrm_pkg.sv]
package amrm_pkg;

    // Field widths of the sample and result ports.
    localparam int SAMPLE_W = 16;
    localparam int OUT_W    = 16;
    localparam int FRAC_W   = 14;
    localparam int CFG_W    = 33;

    // Datapath widths. A cross product component is at most 2^31 in magnitude.
    localparam int MAG_W   = 32;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int REM_W   = MAG_W + 3;
    localparam int NUM_W   = MAG_W + FRAC_W + 1;
    localparam int QUOT_W  = FRAC_W + 1;
    localparam int PROD_W  = 2 * SAMPLE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int ACC_W   = 2 * OUT_W;

    // Stage counts of the normalizer.
    localparam int NORM_STEPS = 5;
    localparam int SQRT_STEPS = MAG_W;
    localparam int DIV_STEPS  = QUOT_W;
    localparam int UNIT_LAT   = 2 + NORM_STEPS + 1 + SQRT_STEPS + 1 + DIV_STEPS + 1;

    // Cycles from an accepted request to its result strobe.
    localparam int LATENCY = UNIT_LAT + 11;

    localparam logic [CFG_W-1:0] MIN_NORM_RESET = CFG_W'(410);

    // One vector handed to a normalizer: component magnitudes and signs.
    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
    } t_vec;

endpackage

[hw/rtl/amrm_unit.sv]
module amrm_unit (
    input  logic                                i_clk,
    input  amrm_pkg::t_vec                      i_vec,
    output logic [amrm_pkg::SQ_W-1:0]           o_sum,
    output logic [2:0][amrm_pkg::OUT_W-1:0]     o_unit
);
    import amrm_pkg::*;

    // Squares and their sum.
    logic [2:0][MAG_W-1:0] r_m0;
    logic [2:0]            r_n0;
    logic [2:0][SQ_W-1:0]  r_sq;

    // Normalizing shift, one binary step per stage.
    logic [SQ_W-1:0]           r_ns   [NORM_STEPS+1];
    logic [2:0][MAG_W-1:0]     r_nmag [NORM_STEPS+1];
    logic [2:0]                r_nneg [NORM_STEPS+1];

    // Square root, one result bit per stage.
    logic [SQ_W-1:0]           r_rad  [SQRT_STEPS];
    logic [REM_W-1:0]          r_rem  [SQRT_STEPS];
    logic [MAG_W-1:0]          r_root [SQRT_STEPS+1];
    logic [2:0][MAG_W-1:0]     r_smag [SQRT_STEPS+1];
    logic [2:0]                r_sneg [SQRT_STEPS+1];

    // Rounded division of each component by the root, one quotient bit per stage.
    logic [2:0][NUM_W-1:0]     r_dx   [DIV_STEPS];
    logic [2:0][MAG_W-1:0]     r_drem [DIV_STEPS];
    logic [2:0][QUOT_W-1:0]    r_dq   [DIV_STEPS+1];
    logic [MAG_W-1:0]          r_dr   [DIV_STEPS+1];
    logic [2:0]                r_dneg [DIV_STEPS+1];

    logic [2:0][OUT_W-1:0]     r_unit;

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_sq[l] <= i_vec.mag[l] * i_vec.mag[l];
        end
        r_m0 <= i_vec.mag;
        r_n0 <= i_vec.neg;

        r_ns[0]   <= r_sq[0] + r_sq[1] + r_sq[2];
        r_nmag[0] <= r_m0;
        r_nneg[0] <= r_n0;
    end

    always_ff @(posedge i_clk) begin
        int sh;
        for (int g = 0; g < NORM_STEPS; g++) begin
            sh = 1 << (NORM_STEPS - 1 - g);
            r_nneg[g+1] <= r_nneg[g];
            if ((r_ns[g] >> (SQ_W - 2 * sh)) == '0) begin
                r_ns[g+1] <= r_ns[g] << (2 * sh);
                for (int l = 0; l < 3; l++) begin
                    r_nmag[g+1][l] <= r_nmag[g][l] << sh;
                end
            end else begin
                r_ns[g+1]   <= r_ns[g];
                r_nmag[g+1] <= r_nmag[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [REM_W-1:0] v_sh;
        logic [REM_W-1:0] v_tr;
        r_rad[0]  <= r_ns[NORM_STEPS];
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_smag[0] <= r_nmag[NORM_STEPS];
        r_sneg[0] <= r_nneg[NORM_STEPS];
        for (int g = 0; g < SQRT_STEPS; g++) begin
            v_sh = {r_rem[g][REM_W-3:0], r_rad[g][SQ_W-1 -: 2]};
            v_tr = REM_W'({r_root[g], 2'b01});
            if (g < SQRT_STEPS - 1) begin
                r_rad[g+1] <= r_rad[g] << 2;
                r_rem[g+1] <= (v_sh >= v_tr) ? v_sh - v_tr : v_sh;
            end
            r_root[g+1] <= {r_root[g][MAG_W-2:0], (v_sh >= v_tr)};
            r_smag[g+1] <= r_smag[g];
            r_sneg[g+1] <= r_sneg[g];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [NUM_W-1:0] v_x;
        logic [MAG_W:0]   v_t;
        int               b;
        for (int l = 0; l < 3; l++) begin
            v_x = NUM_W'({r_smag[SQRT_STEPS][l], FRAC_W'(0)})
                + NUM_W'(r_root[SQRT_STEPS] >> 1);
            r_dx[0][l]   <= v_x;
            r_drem[0][l] <= MAG_W'(v_x >> DIV_STEPS);
        end
        r_dq[0]   <= '0;
        r_dr[0]   <= r_root[SQRT_STEPS];
        r_dneg[0] <= r_sneg[SQRT_STEPS];
        for (int g = 0; g < DIV_STEPS; g++) begin
            b = DIV_STEPS - 1 - g;
            for (int l = 0; l < 3; l++) begin
                v_t = {r_drem[g][l], r_dx[g][l][b]};
                if (g < DIV_STEPS - 1) begin
                    r_dx[g+1][l]   <= r_dx[g][l];
                    r_drem[g+1][l] <= (v_t >= {1'b0, r_dr[g]}) ?
                                      MAG_W'(v_t - {1'b0, r_dr[g]}) : MAG_W'(v_t);
                end
                r_dq[g+1][l] <= {r_dq[g][l][QUOT_W-2:0], (v_t >= {1'b0, r_dr[g]})};
            end
            r_dr[g+1]   <= r_dr[g];
            r_dneg[g+1] <= r_dneg[g];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_unit[l] <= r_dneg[DIV_STEPS][l] ? OUT_W'(0) - OUT_W'(r_dq[DIV_STEPS][l])
                                              : OUT_W'(r_dq[DIV_STEPS][l]);
        end
    end

    assign o_sum  = r_ns[0];
    assign o_unit = r_unit;

endmodule

[hw/rtl/accel_mag_rotation_matrix.sv]
// Channel      Direction  Handshake                  Content
// request      in         start / busy               accel x,y,z (Q8.8), geo x,y,z (Q12.4)
// config       in         i_cfg_valid / o_cfg_ready  min_cross_norm (33 bits, 12 frac bits)
// result       out        o_result_valid strobe      rotation rows H, M, A, inclination, status
//
// One request is taken every cycle; busy is never raised. The delay from request
// to result is set mostly by the 32-stage square root and 15-stage divider inside
// each normalizer. The result is shown for one cycle only, since the receiver
// cannot stall. Reset clears the valid pipeline and loads the threshold with its
// reset value; data registers are not reset.
module accel_mag_rotation_matrix (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [amrm_pkg::SAMPLE_W-1:0]  i_accel_x,
    input  logic signed [amrm_pkg::SAMPLE_W-1:0]  i_accel_y,
    input  logic signed [amrm_pkg::SAMPLE_W-1:0]  i_accel_z,
    input  logic signed [amrm_pkg::SAMPLE_W-1:0]  i_geo_x,
    input  logic signed [amrm_pkg::SAMPLE_W-1:0]  i_geo_y,
    input  logic signed [amrm_pkg::SAMPLE_W-1:0]  i_geo_z,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [amrm_pkg::CFG_W-1:0]            i_cfg_data,
    output logic                                  o_result_valid,
    output logic signed [amrm_pkg::OUT_W-1:0]     o_rot_00,
    output logic signed [amrm_pkg::OUT_W-1:0]     o_rot_01,
    output logic signed [amrm_pkg::OUT_W-1:0]     o_rot_02,
    output logic signed [amrm_pkg::OUT_W-1:0]     o_rot_10,
    output logic signed [amrm_pkg::OUT_W-1:0]     o_rot_11,
    output logic signed [amrm_pkg::OUT_W-1:0]     o_rot_12,
    output logic signed [amrm_pkg::OUT_W-1:0]     o_rot_20,
    output logic signed [amrm_pkg::OUT_W-1:0]     o_rot_21,
    output logic signed [amrm_pkg::OUT_W-1:0]     o_rot_22,
    output logic signed [amrm_pkg::OUT_W-1:0]     o_incl_cos,
    output logic signed [amrm_pkg::OUT_W-1:0]     o_incl_sin,
    output logic                                  o_status
);
    import amrm_pkg::*;

    localparam int DG_LEN = UNIT_LAT + 4;
    localparam logic signed [ACC_W:0] P_ONE = (ACC_W+1)'(1) <<< FRAC_W;
    localparam logic signed [ACC_W:0] N_ONE = -P_ONE;
    localparam logic signed [ACC_W:0] HALF  = (ACC_W+1)'(1) <<< (FRAC_W - 1);

    // Round a product sum with 2*FRAC_W fraction bits to FRAC_W bits, half up,
    // then clamp to the unit range.
    function automatic logic [OUT_W-1:0] rnd_sat(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W:0] t;
        logic signed [ACC_W:0] q;
        t = $signed({x[ACC_W-1], x}) + HALF;
        q = t >>> FRAC_W;
        if (q > P_ONE) begin
            return OUT_W'(P_ONE);
        end else if (q < N_ONE) begin
            return OUT_W'(N_ONE);
        end else begin
            return OUT_W'(q);
        end
    endfunction

    logic                    accept;
    logic [LATENCY-1:0]      r_vld;
    logic [CFG_W-1:0]        r_min;
    logic [SQ_W-1:0]         r_min_sq;

    logic signed [SAMPLE_W-1:0] r_acc  [3];
    logic signed [SAMPLE_W-1:0] r_geo  [3];
    logic signed [SAMPLE_W-1:0] r_acc2 [3];
    logic signed [SAMPLE_W-1:0] r_geo2 [3];
    logic signed [SAMPLE_W-1:0] r_acc3 [3];
    logic signed [SAMPLE_W-1:0] r_geo3 [3];
    logic signed [PROD_W-1:0]   r_p    [6];
    logic signed [CROSS_W-1:0]  r_h    [3];
    t_vec                       r_hv;
    t_vec                       r_av;
    t_vec                       r_ev;

    logic [SQ_W-1:0]            sum_h;
    logic [2:0][OUT_W-1:0]      uh;
    logic [2:0][OUT_W-1:0]      ua;
    logic [2:0][OUT_W-1:0]      ue;
    logic [DG_LEN-1:0]          r_dg;

    logic signed [ACC_W-1:0]    r_mp [6];
    logic signed [ACC_W-1:0]    r_sp [3];
    logic signed [ACC_W-1:0]    r_mr [3];
    logic signed [ACC_W-1:0]    r_sr;
    logic [2:0][OUT_W-1:0]      r_m;
    logic [OUT_W-1:0]           r_sin;
    logic signed [ACC_W-1:0]    r_cp [3];
    logic signed [ACC_W-1:0]    r_cs;
    logic [OUT_W-1:0]           r_cos;

    logic [5:0][2:0][OUT_W-1:0] r_hd;
    logic [5:0][2:0][OUT_W-1:0] r_ad;
    logic [2:0][2:0][OUT_W-1:0] r_ed;
    logic [2:0][2:0][OUT_W-1:0] r_md;
    logic [2:0][OUT_W-1:0]      r_sind;

    logic [2:0][OUT_W-1:0]      r_out_h;
    logic [2:0][OUT_W-1:0]      r_out_m;
    logic [2:0][OUT_W-1:0]      r_out_a;
    logic [OUT_W-1:0]           r_out_cos;
    logic [OUT_W-1:0]           r_out_sin;
    logic                       r_out_status;

    // Fully pipelined: requests and register writes are always taken.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_min <= MIN_NORM_RESET;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], accept};
            if (i_cfg_valid && o_cfg_ready) begin
                r_min <= i_cfg_data;
            end
        end
    end

    // The threshold is compared in squared form against |H|^2.
    always_ff @(posedge i_clk) begin
        r_min_sq <= r_min[MAG_W-1:0] * r_min[MAG_W-1:0];
    end

    // Capture the sample pair, form the six cross products, then H = geo x accel.
    always_ff @(posedge i_clk) begin
        r_acc[0] <= i_accel_x;
        r_acc[1] <= i_accel_y;
        r_acc[2] <= i_accel_z;
        r_geo[0] <= i_geo_x;
        r_geo[1] <= i_geo_y;
        r_geo[2] <= i_geo_z;

        r_p[0] <= r_geo[1] * r_acc[2];
        r_p[1] <= r_geo[2] * r_acc[1];
        r_p[2] <= r_geo[2] * r_acc[0];
        r_p[3] <= r_geo[0] * r_acc[2];
        r_p[4] <= r_geo[0] * r_acc[1];
        r_p[5] <= r_geo[1] * r_acc[0];
        r_acc2 <= r_acc;
        r_geo2 <= r_geo;

        for (int i = 0; i < 3; i++) begin
            r_h[i] <= CROSS_W'(r_p[2*i]) - CROSS_W'(r_p[2*i+1]);
        end
        r_acc3 <= r_acc2;
        r_geo3 <= r_geo2;
    end

    // Split every vector into magnitudes and signs for the normalizers.
    always_ff @(posedge i_clk) begin
        logic signed [SAMPLE_W:0] v_a;
        logic signed [SAMPLE_W:0] v_g;
        for (int i = 0; i < 3; i++) begin
            v_a = (SAMPLE_W+1)'(r_acc3[i]);
            v_g = (SAMPLE_W+1)'(r_geo3[i]);
            r_hv.neg[i] <= r_h[i][CROSS_W-1];
            r_hv.mag[i] <= r_h[i][CROSS_W-1] ? MAG_W'(-r_h[i]) : MAG_W'(r_h[i]);
            r_av.neg[i] <= v_a[SAMPLE_W];
            r_av.mag[i] <= v_a[SAMPLE_W] ? MAG_W'(-v_a) : MAG_W'(v_a);
            r_ev.neg[i] <= v_g[SAMPLE_W];
            r_ev.mag[i] <= v_g[SAMPLE_W] ? MAG_W'(-v_g) : MAG_W'(v_g);
        end
    end

    amrm_unit u_unit_h (
        .i_clk  (i_clk),
        .i_vec  (r_hv),
        .o_sum  (sum_h),
        .o_unit (uh)
    );

    amrm_unit u_unit_a (
        .i_clk  (i_clk),
        .i_vec  (r_av),
        .o_sum  (),
        .o_unit (ua)
    );

    amrm_unit u_unit_e (
        .i_clk  (i_clk),
        .i_vec  (r_ev),
        .o_sum  (),
        .o_unit (ue)
    );

    // The degenerate decision is made as soon as |H|^2 is known and then
    // travels alongside the normalizers. A zero H is always degenerate, and a
    // threshold of 2^32 or more exceeds any |H|.
    always_ff @(posedge i_clk) begin
        r_dg <= {r_dg[DG_LEN-2:0],
                 (sum_h == '0) || r_min[CFG_W-1] || (sum_h < r_min_sq)};
    end

    // M = A x H and sin = E.A, then cos = E.M once M is rounded.
    always_ff @(posedge i_clk) begin
        r_mp[0] <= $signed(ua[1]) * $signed(uh[2]);
        r_mp[1] <= $signed(ua[2]) * $signed(uh[1]);
        r_mp[2] <= $signed(ua[2]) * $signed(uh[0]);
        r_mp[3] <= $signed(ua[0]) * $signed(uh[2]);
        r_mp[4] <= $signed(ua[0]) * $signed(uh[1]);
        r_mp[5] <= $signed(ua[1]) * $signed(uh[0]);
        for (int i = 0; i < 3; i++) begin
            r_sp[i] <= $signed(ue[i]) * $signed(ua[i]);
        end

        for (int i = 0; i < 3; i++) begin
            r_mr[i] <= r_mp[2*i] - r_mp[2*i+1];
        end
        r_sr <= r_sp[0] + r_sp[1] + r_sp[2];

        for (int i = 0; i < 3; i++) begin
            r_m[i] <= rnd_sat(r_mr[i]);
        end
        r_sin <= rnd_sat(r_sr);

        for (int i = 0; i < 3; i++) begin
            r_cp[i] <= $signed(r_ed[2][i]) * $signed(r_m[i]);
        end
        r_cs  <= r_cp[0] + r_cp[1] + r_cp[2];
        r_cos <= rnd_sat(r_cs);

        r_hd   <= {r_hd[4:0], uh};
        r_ad   <= {r_ad[4:0], ua};
        r_ed   <= {r_ed[1:0], ue};
        r_md   <= {r_md[1:0], r_m};
        r_sind <= {r_sind[1:0], r_sin};
    end

    // Output register: a degenerate pair forces every value to zero.
    always_ff @(posedge i_clk) begin
        r_out_status <= r_dg[DG_LEN-1];
        if (r_dg[DG_LEN-1]) begin
            r_out_h   <= '0;
            r_out_m   <= '0;
            r_out_a   <= '0;
            r_out_cos <= '0;
            r_out_sin <= '0;
        end else begin
            r_out_h   <= r_hd[5];
            r_out_m   <= r_md[2];
            r_out_a   <= r_ad[5];
            r_out_cos <= r_cos;
            r_out_sin <= r_sind[2];
        end
    end

    assign o_result_valid = r_vld[LATENCY-1];
    assign o_rot_00   = $signed(r_out_h[0]);
    assign o_rot_01   = $signed(r_out_h[1]);
    assign o_rot_02   = $signed(r_out_h[2]);
    assign o_rot_10   = $signed(r_out_m[0]);
    assign o_rot_11   = $signed(r_out_m[1]);
    assign o_rot_12   = $signed(r_out_m[2]);
    assign o_rot_20   = $signed(r_out_a[0]);
    assign o_rot_21   = $signed(r_out_a[1]);
    assign o_rot_22   = $signed(r_out_a[2]);
    assign o_incl_cos = $signed(r_out_cos);
    assign o_incl_sin = $signed(r_out_sin);
    assign o_status   = r_out_status;

endmodule

[hw/rtl/amrm_chk.sv]
module amrm_chk (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic                                  o_result_valid,
    input logic                                  o_status,
    input logic signed [amrm_pkg::OUT_W-1:0]     o_rot_00,
    input logic signed [amrm_pkg::OUT_W-1:0]     o_rot_11,
    input logic signed [amrm_pkg::OUT_W-1:0]     o_rot_20,
    input logic signed [amrm_pkg::OUT_W-1:0]     o_rot_22,
    input logic signed [amrm_pkg::OUT_W-1:0]     o_incl_cos,
    input logic signed [amrm_pkg::OUT_W-1:0]     o_incl_sin
);
    import amrm_pkg::*;

    localparam logic signed [OUT_W-1:0] P_ONE = OUT_W'(1) <<< FRAC_W;
    localparam logic signed [OUT_W-1:0] N_ONE = -P_ONE;

    // Every accepted request yields exactly one result after the fixed latency.
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_result_valid)
        else $error("request without result");

    a_result_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, LATENCY))
        else $error("result without request");

    // A degenerate result carries zeros only.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status) |->
            (o_rot_00 == '0 && o_rot_11 == '0 && o_rot_22 == '0 &&
             o_incl_cos == '0 && o_incl_sin == '0))
        else $error("degenerate result not zeroed");

    // Results stay within the unit range.
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |->
            (o_rot_20 <= P_ONE && o_rot_20 >= N_ONE &&
             o_incl_cos <= P_ONE && o_incl_cos >= N_ONE))
        else $error("result outside unit range");

endmodule

bind accel_mag_rotation_matrix amrm_chk u_amrm_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_status       (o_status),
    .o_rot_00       (o_rot_00),
    .o_rot_11       (o_rot_11),
    .o_rot_20       (o_rot_20),
    .o_rot_22       (o_rot_22),
    .o_incl_cos     (o_incl_cos),
    .o_incl_sin     (o_incl_sin)
);

[tb/sv/tb_accel_mag_rotation_matrix.sv]
`timescale 1ns / 100ps

module tb_accel_mag_rotation_matrix;

    import amrm_pkg::*;

    // One orientation result: nine matrix entries, two inclination terms, status.
    typedef struct {
        logic signed [OUT_W-1:0] rot [9];
        logic signed [OUT_W-1:0] incl_cos;
        logic signed [OUT_W-1:0] incl_sin;
        logic                    status;
    } t_orient;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic signed [SAMPLE_W-1:0]  i_accel_x = '0;
    logic signed [SAMPLE_W-1:0]  i_accel_y = '0;
    logic signed [SAMPLE_W-1:0]  i_accel_z = '0;
    logic signed [SAMPLE_W-1:0]  i_geo_x = '0;
    logic signed [SAMPLE_W-1:0]  i_geo_y = '0;
    logic signed [SAMPLE_W-1:0]  i_geo_z = '0;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_W-1:0]            i_cfg_data = '0;
    logic                        o_result_valid;
    logic signed [OUT_W-1:0]     o_rot_00, o_rot_01, o_rot_02;
    logic signed [OUT_W-1:0]     o_rot_10, o_rot_11, o_rot_12;
    logic signed [OUT_W-1:0]     o_rot_20, o_rot_21, o_rot_22;
    logic signed [OUT_W-1:0]     o_incl_cos, o_incl_sin;
    logic                        o_status;

    // The predictor keeps its own copy of the threshold register.
    logic [CFG_W-1:0] min_norm_shadow = MIN_NORM_RESET;
    t_orient          orient_queue [$];
    int               fail_count = 0;

    always #1 i_clk = ~i_clk;

    accel_mag_rotation_matrix DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_accel_z      (i_accel_z),
        .i_geo_x        (i_geo_x),
        .i_geo_y        (i_geo_y),
        .i_geo_z        (i_geo_z),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_rot_00       (o_rot_00),
        .o_rot_01       (o_rot_01),
        .o_rot_02       (o_rot_02),
        .o_rot_10       (o_rot_10),
        .o_rot_11       (o_rot_11),
        .o_rot_12       (o_rot_12),
        .o_rot_20       (o_rot_20),
        .o_rot_21       (o_rot_21),
        .o_rot_22       (o_rot_22),
        .o_incl_cos     (o_incl_cos),
        .o_incl_sin     (o_incl_sin),
        .o_status       (o_status)
    );

    // Bit-serial integer square root, floor of sqrt(n).
    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Rounds a product sum with 2*FRAC_W fraction bits to FRAC_W bits, half up,
    // and clamps it to plus or minus one.
    function automatic longint round_clamp(longint x);
        longint q;
        q = (x + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
        if (q > (longint'(1) << FRAC_W)) q = longint'(1) << FRAC_W;
        if (q < -(longint'(1) << FRAC_W)) q = -(longint'(1) << FRAC_W);
        return q;
    endfunction

    // Scales a vector to unit length. The sum of squares is normalized into the
    // top two bits by an even shift so the root keeps full precision.
    function automatic void unit_vector(input longint v [3], output longint u [3]);
        logic [63:0] mag [3];
        logic [63:0] sumsq;
        logic [63:0] root;
        logic [63:0] quot;
        logic [127:0] num;
        int          k;
        sumsq = 0;
        k     = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
            sumsq  = sumsq + mag[i] * mag[i];
        end
        if (sumsq == 0) begin
            for (int i = 0; i < 3; i++) u[i] = 0;
            return;
        end
        while (sumsq < (64'd1 << 62)) begin
            sumsq = sumsq << 2;
            k++;
        end
        root = int_sqrt(sumsq);
        for (int i = 0; i < 3; i++) begin
            num  = (128'(mag[i]) << k) << FRAC_W;
            quot = 64'((num + 128'(root >> 1)) / 128'(root));
            if (quot > (64'd1 << FRAC_W)) quot = 64'd1 << FRAC_W;
            u[i] = v[i] < 0 ? -longint'(quot) : longint'(quot);
        end
    endfunction

    // Works out the orientation result for one accel/geo sample pair.
    function automatic t_orient predict_orientation(
        input logic signed [SAMPLE_W-1:0] ax, ay, az, gx, gy, gz);
        t_orient     res;
        longint      acc [3];
        longint      geo [3];
        longint      east_raw [3];
        longint      east [3];
        longint      grav [3];
        longint      geo_unit [3];
        longint      north [3];
        logic [63:0] cross_sq;
        logic [63:0] mg;
        logic        degenerate;
        acc[0] = ax; acc[1] = ay; acc[2] = az;
        geo[0] = gx; geo[1] = gy; geo[2] = gz;
        east_raw[0] = geo[1] * acc[2] - geo[2] * acc[1];
        east_raw[1] = geo[2] * acc[0] - geo[0] * acc[2];
        east_raw[2] = geo[0] * acc[1] - geo[1] * acc[0];
        cross_sq = 0;
        for (int i = 0; i < 3; i++) begin
            mg       = east_raw[i] < 0 ? 64'(-east_raw[i]) : 64'(east_raw[i]);
            cross_sq = cross_sq + mg * mg;
        end
        // A zero cross product is degenerate even with a zero threshold, and a
        // threshold of 2^32 or more can never be met.
        if (cross_sq == 0 || min_norm_shadow[32])
            degenerate = 1'b1;
        else
            degenerate = cross_sq < 64'(min_norm_shadow) * 64'(min_norm_shadow);
        if (degenerate) begin
            for (int i = 0; i < 9; i++) res.rot[i] = '0;
            res.incl_cos = '0;
            res.incl_sin = '0;
            res.status   = 1'b1;
            return res;
        end
        unit_vector(east_raw, east);
        unit_vector(acc, grav);
        unit_vector(geo, geo_unit);
        north[0] = round_clamp(grav[1] * east[2] - grav[2] * east[1]);
        north[1] = round_clamp(grav[2] * east[0] - grav[0] * east[2]);
        north[2] = round_clamp(grav[0] * east[1] - grav[1] * east[0]);
        for (int i = 0; i < 3; i++) begin
            res.rot[i]     = OUT_W'(east[i]);
            res.rot[3 + i] = OUT_W'(north[i]);
            res.rot[6 + i] = OUT_W'(grav[i]);
        end
        res.incl_cos = OUT_W'(round_clamp(geo_unit[0] * north[0] + geo_unit[1] * north[1]
                                          + geo_unit[2] * north[2]));
        res.incl_sin = OUT_W'(round_clamp(geo_unit[0] * grav[0] + geo_unit[1] * grav[1]
                                          + geo_unit[2] * grav[2]));
        res.status   = 1'b0;
        return res;
    endfunction

    // Result checker: every strobe is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_orient exp_res;
        logic signed [OUT_W-1:0] got [9];
        if (i_rst_n && o_result_valid) begin
            if (orient_queue.size() == 0) begin
                $error("result strobe with no request outstanding");
                fail_count++;
            end else begin
                exp_res = orient_queue.pop_front();
                got = '{o_rot_00, o_rot_01, o_rot_02, o_rot_10, o_rot_11, o_rot_12,
                        o_rot_20, o_rot_21, o_rot_22};
                for (int i = 0; i < 9; i++) begin
                    if (got[i] !== exp_res.rot[i]) begin
                        $error("rot_%0d%0d: expected %0d, got %0d", i / 3, i % 3,
                               exp_res.rot[i], got[i]);
                        fail_count++;
                    end
                end
                if (o_incl_cos !== exp_res.incl_cos) begin
                    $error("incl_cos: expected %0d, got %0d", exp_res.incl_cos, o_incl_cos);
                    fail_count++;
                end
                if (o_incl_sin !== exp_res.incl_sin) begin
                    $error("incl_sin: expected %0d, got %0d", exp_res.incl_sin, o_incl_sin);
                    fail_count++;
                end
                if (o_status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, o_status);
                    fail_count++;
                end
            end
        end
    end

    // Mostly short gaps, now and then a long one, and runs with none at all.
    // Start drops only when a gap is actually taken.
    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 50) n = 0;
        else if (n < 93) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 60);
        if (n > 0) start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Sends one request and records its predicted result once it is taken.
    // Start stays high afterwards so the next request can follow without a gap.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] ax, ay, az, gx, gy, gz,
                               input bit with_gap = 1);
        if (with_gap) idle_gap();
        start     <= 1'b1;
        i_accel_x <= ax;
        i_accel_y <= ay;
        i_accel_z <= az;
        i_geo_x   <= gx;
        i_geo_y   <= gy;
        i_geo_z   <= gz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        orient_queue.push_back(predict_orientation(ax, ay, az, gx, gy, gz));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (orient_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // The threshold is only changed with the pipeline empty.
    task automatic write_threshold(input logic [CFG_W-1:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        min_norm_shadow = value;
        i_cfg_valid <= 1'b0;
    endtask

    // A physically plausible pair: accel components up to about 9.8 m/s^2 in Q8.8 and
    // field components of tens of microtesla in Q12.4, with random orientation and noise.
    task automatic send_plausible();
        send_sample(SAMPLE_W'($urandom_range(0, 5000) - 2500),
                    SAMPLE_W'($urandom_range(0, 5000) - 2500),
                    SAMPLE_W'($urandom_range(0, 5000) - 2500),
                    SAMPLE_W'($urandom_range(0, 1600) - 800),
                    SAMPLE_W'($urandom_range(0, 1600) - 800),
                    SAMPLE_W'($urandom_range(0, 1600) - 800));
    endtask

    task automatic test_directed_extremes();
        logic signed [SAMPLE_W-1:0] mx;
        logic signed [SAMPLE_W-1:0] mn;
        mx = 16'sh7FFF;
        mn = 16'sh8000;
        send_sample(0, 0, 2509, 320, 0, -640);      // level and pointing north
        send_sample(0, 0, 0, 320, 100, -640);       // zero gravity gives zero cross
        send_sample(0, 0, 2509, 0, 0, 0);           // zero field
        send_sample(0, 0, 2509, 0, 0, 700);         // parallel vectors
        send_sample(mx, mx, mx, mn, mn, mn);        // antiparallel at full scale
        send_sample(mx, 0, 0, 0, mx, 0);
        send_sample(mn, 0, 0, 0, mn, 0);
        send_sample(mn, mn, mx, mx, mn, mn);
        send_sample(mx, mn, 0, 0, mx, mn);
        send_sample(1, 0, 0, 0, 1, 0);              // smallest nonzero cross product
        send_sample(-1, 0, 0, 0, 0, 1);
        send_sample(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
        send_sample(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
        send_sample(0, 2509, 0, 0, 300, 500);
    endtask

    // Cross magnitudes either side of the reset threshold of about 0.1.
    task automatic test_threshold_edge();
        send_sample(1, 0, 0, 0, 409, 0);
        send_sample(1, 0, 0, 0, 410, 0);
        send_sample(1, 0, 0, 0, 411, 0);
        // With a zero threshold only a zero cross product is degenerate.
        write_threshold('0);
        send_sample(1, 0, 0, 0, 1, 0);
        send_sample(5, 5, 5, 7, 7, 7);
        // The largest threshold below 2^32, then values at and above 2^32.
        write_threshold(CFG_W'(64'hFFFF_FFFF));
        send_sample(16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0);
        send_sample(16'sh8000, 0, 0, 0, 16'sh8000, 0);
        write_threshold(CFG_W'(64'h1_0000_0000));
        send_sample(16'sh8000, 0, 0, 0, 16'sh8000, 0);
        write_threshold({CFG_W{1'b1}});
        send_sample(16'sh8000, 0, 0, 0, 16'sh8000, 0);
        write_threshold(MIN_NORM_RESET);
    endtask

    // Back-to-back requests with no gaps, so that many are in flight at once.
    task automatic test_full_rate();
        for (int i = 0; i < 60; i++) begin
            send_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                        SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom), 0);
        end
        // The sender holds off until every outstanding result has arrived.
        drain_results();
    endtask

    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 7) begin
                send_plausible();
            end else if ($urandom_range(0, 1) == 0) begin
                send_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                            SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
            end else begin
                // Small vectors give cross magnitudes that probe the degenerate boundary.
                send_sample(SAMPLE_W'($urandom_range(0, 8) - 4),
                            SAMPLE_W'($urandom_range(0, 8) - 4),
                            SAMPLE_W'($urandom_range(0, 8) - 4),
                            SAMPLE_W'($urandom_range(0, 400) - 200),
                            SAMPLE_W'($urandom_range(0, 400) - 200),
                            SAMPLE_W'($urandom_range(0, 400) - 200));
            end
        end
    endtask

    task automatic test_threshold_sweep();
        write_threshold(CFG_W'($urandom_range(0, 100000)));
        test_random_mix(150);
        write_threshold(CFG_W'($urandom_range(1000000, 40000000)));
        test_random_mix(150);
        write_threshold(CFG_W'({$urandom, $urandom}));
        test_random_mix(60);
        write_threshold(MIN_NORM_RESET);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_threshold_edge();
        test_full_rate();
        test_random_mix(400);
        test_threshold_sweep();
        drain_results();
        if (fail_count == 0 && orient_queue.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[accel_mag_rotation_matrix.f]
hw/rtl/amrm_pkg.sv
hw/rtl/amrm_unit.sv
hw/rtl/accel_mag_rotation_matrix.sv
hw/rtl/amrm_chk.sv
tb/sv/tb_accel_mag_rotation_matrix.sv
